/* rtl/core/mes_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time shader.
package mes_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 28;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int IN_W     = 31;  // c_real / c_imag width on the ports
	localparam int CFG_W    = 16;  // max_iterations register width
	localparam int OCOUNT_W = 16;  // escape_count width on the port
	localparam int SHADE_W  = 8;
	localparam int SQ_W     = 18;  // (2s+1)^2 for s up to 255

	localparam logic [CFG_W-1:0] MAX_ITER_RESET = 16'd500;
	localparam logic [SQ_W-1:0]  SHADE_SCALE    = 18'd260100;  // 510^2

	typedef struct packed {
		logic               done;
		logic [SHADE_W-1:0] value;
	} shade_res_t;

endpackage

/* rtl/core/mandelbrot_escape_shade_top.sv */
// Top level: escape-time iteration of one point with brightness shade.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_stall    | c_real, c_imag (signed Q3.28, 31 b)
//  out      | out_valid / out_stall  | escape_count, escaped, shade
//  cfg      | cfg_wen                | cfg_wdata (max_iterations)
//
//  One word in, one word out. An iteration steps through ST_SQR, ST_SQI,
//  ST_CRS and ST_UPD on the shared multiplier (z_r^2, z_i^2, z_r*z_i, then
//  update); an escape then runs the shade search (eight bitwise steps plus
//  a tie check).
//  in_stall is high from acceptance until the result is in the output
//  register; a waiting result does not block the next word.
//  arst_n clears control and sets max_iterations to 500.
module mandelbrot_escape_shade_top #(
	parameter int COORD_WIDTH = mes_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = mes_pkg::FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = mes_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [mes_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [mes_pkg::IN_W-1:0]     c_real,
	input  logic signed [mes_pkg::IN_W-1:0]     c_imag,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mes_pkg::OCOUNT_W-1:0]        escape_count,
	output logic                                escaped,
	output logic [mes_pkg::SHADE_W-1:0]         shade
);

	// working width: holds 2*z_r*z_i and any sum of two coordinates
	localparam int WW = 2*COORD_WIDTH + 2;
	// escape compare width: wide enough for the limit 4.0 (2.0 squared) at any FRAC_BITS
	localparam int EW = (WW > 2*FRAC_BITS + 4) ? WW : 2*FRAC_BITS + 4;

	localparam logic signed [WW-1:0] C_MAX_W =
		{{(WW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [WW-1:0] C_MIN_W =
		{{(WW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [EW-1:0] ESC_LIM = {{(EW-1){1'b0}}, 1'b1} << (2*FRAC_BITS + 2);

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQR  = 3'd1;  // limit check, issue z_r*z_r
	localparam logic [2:0] ST_SQI  = 3'd2;  // take z_r^2, issue z_i*z_i
	localparam logic [2:0] ST_CRS  = 3'd3;  // take z_i^2, issue z_r*z_i, magnitude test
	localparam logic [2:0] ST_UPD  = 3'd4;  // escape or new z
	localparam logic [2:0] ST_SHD  = 3'd5;  // wait on shade search
	localparam logic [2:0] ST_DONE = 3'd6;  // hand result to output register

	function automatic logic signed [COORD_WIDTH-1:0] sat_c(input logic signed [WW-1:0] x);
		logic signed [COORD_WIDTH-1:0] r;
		if (x > C_MAX_W)
			r = C_MAX_W[COORD_WIDTH-1:0];
		else if (x < C_MIN_W)
			r = C_MIN_W[COORD_WIDTH-1:0];
		else
			r = x[COORD_WIDTH-1:0];
		return r;
	endfunction

	logic [2:0]                        state_q;
	logic [mes_pkg::CFG_W-1:0]         max_iter_q;
	logic [COUNT_WIDTH-1:0]            limit;
	logic [COUNT_WIDTH-1:0]            cnt_q;
	logic signed [COORD_WIDTH-1:0]     cr_q, ci_q, zr_q, zi_q;
	logic signed [2*COORD_WIDTH-1:0]   sq_r_q, sq_i_q;
	logic                              esc_hit_q;
	logic                              esc_q;
	logic [mes_pkg::SHADE_W-1:0]       shade_r_q;

	logic signed [COORD_WIDTH-1:0]     mul_a, mul_b;
	logic signed [2*COORD_WIDTH-1:0]   mul_p;
	logic [EW-1:0]                     mag_sum;

	logic signed [WW-1:0]              re_w, im_w, re_sum, im_sum;
	logic signed [COORD_WIDTH-1:0]     re_s, im_s, zr_next, zi_next;

	logic                              shd_start;
	mes_pkg::shade_res_t               shd_res;

	logic                              accept;
	logic                              load_out;

	logic                              out_valid_q;
	logic [mes_pkg::OCOUNT_W-1:0]      escape_count_q;
	logic                              escaped_q;
	logic [mes_pkg::SHADE_W-1:0]       shade_q;

	assign limit    = COUNT_WIDTH'(max_iter_q);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_SQI:  begin mul_a = zi_q; mul_b = zi_q; end
			ST_CRS:  begin mul_a = zr_q; mul_b = zi_q; end
			default: begin mul_a = zr_q; mul_b = zr_q; end
		endcase
	end

	mes_mul #(
		.W (COORD_WIDTH)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// |z|^2 from z_r^2 (held) and z_i^2 (fresh product)
	assign mag_sum = EW'($unsigned(sq_r_q)) + EW'($unsigned(mul_p));

	// z update: products floored by FRAC_BITS, saturated, plus c, saturated
	assign re_w    = (WW'(sq_r_q) - WW'(sq_i_q)) >>> FRAC_BITS;
	assign im_w    = (WW'(mul_p) + WW'(mul_p)) >>> FRAC_BITS;
	assign re_s    = sat_c(re_w);
	assign im_s    = sat_c(im_w);
	assign re_sum  = WW'(re_s) + WW'(cr_q);
	assign im_sum  = WW'(im_s) + WW'(ci_q);
	assign zr_next = sat_c(re_sum);
	assign zi_next = sat_c(im_sum);

	assign shd_start = (state_q == ST_UPD) && esc_hit_q;

	mes_shade #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_shade (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (shd_start),
		.k      (cnt_q),
		.m      (limit),
		.res    (shd_res)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cr_q <= sat_c(WW'(c_real));
					ci_q <= sat_c(WW'(c_imag));
					zr_q <= sat_c(WW'(c_real));
					zi_q <= sat_c(WW'(c_imag));
				end
			end
			ST_SQR: begin
				shade_r_q <= '0;
			end
			ST_SQI: begin
				sq_r_q <= mul_p;
			end
			ST_CRS: begin
				sq_i_q    <= mul_p;
				esc_hit_q <= (mag_sum > ESC_LIM);
			end
			ST_UPD: begin
				if (!esc_hit_q) begin
					zr_q <= zr_next;
					zi_q <= zi_next;
				end
			end
			ST_SHD: begin
				if (shd_res.done)
					shade_r_q <= shd_res.value;
			end
			default: ;
		endcase
	end

	// sequencer and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			esc_q      <= 1'b0;
			max_iter_q <= mes_pkg::MAX_ITER_RESET;
		end else begin
			if (cfg_wen)
				max_iter_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						esc_q   <= 1'b0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (cnt_q == limit)
						state_q <= ST_DONE;
					else
						state_q <= ST_SQI;
				end
				ST_SQI: state_q <= ST_CRS;
				ST_CRS: state_q <= ST_UPD;
				ST_UPD: begin
					if (esc_hit_q) begin
						esc_q   <= 1'b1;
						state_q <= ST_SHD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_SQR;
					end
				end
				ST_SHD: begin
					if (shd_res.done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: the result word waits here while the next point runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			escape_count_q <= mes_pkg::OCOUNT_W'(cnt_q);
			escaped_q      <= esc_q;
			shade_q        <= shade_r_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = escape_count_q;
	assign escaped      = escaped_q;
	assign shade        = shade_q;

endmodule

/* rtl/core/mes_mul.sv */
// Shared signed multiplier with registered product.
module mes_mul #(
	parameter int W = mes_pkg::COORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	logic signed [2*W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

/* rtl/core/mes_shade.sv */
// Shade search: round(255*sqrt(k/m)) by bitwise search with exact compares.
module mes_shade #(
	parameter int COUNT_WIDTH = mes_pkg::COUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [COUNT_WIDTH-1:0]  k,
	input  logic [COUNT_WIDTH-1:0]  m,
	output mes_pkg::shade_res_t     res
);

	localparam int PW = mes_pkg::SQ_W + COUNT_WIDTH;

	localparam logic [1:0] SH_IDLE = 2'd0;
	localparam logic [1:0] SH_SQ   = 2'd1;
	localparam logic [1:0] SH_CMP  = 2'd2;

	logic [1:0]                    state_q;
	logic [2:0]                    bit_q;
	logic                          tie_q;
	logic                          done_q;
	logic [mes_pkg::SHADE_W-1:0]   res_q;
	logic [mes_pkg::SHADE_W-1:0]   trial;
	logic [mes_pkg::SHADE_W:0]     odd;
	logic [mes_pkg::SQ_W-1:0]      osq_q;
	logic [PW-1:0]                 rhs_q;
	logic [PW-1:0]                 lhs;
	logic [COUNT_WIDTH-1:0]        m_q;

	assign trial = res_q | (mes_pkg::SHADE_W'(1) << bit_q);
	// odd = 2*trial-1 during the search, 2*res+1 for the tie check
	assign odd   = tie_q ? {res_q, 1'b1} : ({trial, 1'b0} - 1'b1);
	assign lhs   = PW'(osq_q) * PW'(m_q);

	always_ff @(posedge clk) begin
		case (state_q)
			SH_IDLE: begin
				if (start) begin
					rhs_q <= PW'(mes_pkg::SHADE_SCALE) * PW'(k);
					m_q   <= m;
				end
			end
			SH_SQ: begin
				osq_q <= mes_pkg::SQ_W'(odd) * mes_pkg::SQ_W'(odd);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SH_IDLE;
			bit_q   <= '0;
			tie_q   <= 1'b0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SH_IDLE: begin
					if (start) begin
						res_q   <= '0;
						bit_q   <= 3'd7;
						tie_q   <= 1'b0;
						state_q <= SH_SQ;
					end
				end
				SH_SQ: begin
					state_q <= SH_CMP;
				end
				SH_CMP: begin
					if (!tie_q) begin
						if (lhs < rhs_q)
							res_q <= trial;
						if (bit_q == 3'd0)
							tie_q <= 1'b1;
						else
							bit_q <= bit_q - 1'b1;
						state_q <= SH_SQ;
					end else begin
						// exact half: round to the even shade
						if ((res_q != '1) && (lhs == rhs_q) && res_q[0])
							res_q <= res_q + 1'b1;
						done_q  <= 1'b1;
						state_q <= SH_IDLE;
					end
				end
				default: state_q <= SH_IDLE;
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.value = res_q;

endmodule

/* rtl/core/mes_checker.sv */
// Port-level checker for the escape-time shader, bound to the top level.
module mes_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [mes_pkg::OCOUNT_W-1:0]    escape_count,
	input logic                            escaped,
	input logic [mes_pkg::SHADE_W-1:0]     shade
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// an accepted point keeps the input side busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not held off after acceptance");

	// points inside the set are black
	a_inside_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !escaped |-> shade == '0)
		else $error("non-zero shade for a point that did not escape");

	// immediate escape gives zero shade
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (escape_count == '0) |-> shade == '0)
		else $error("non-zero shade at zero count");

endmodule

bind mandelbrot_escape_shade_top mes_checker u_mes_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.escape_count (escape_count),
	.escaped      (escaped),
	.shade        (shade)
);
